// File: design/dtcs_pkg.sv
// Shared types and constants for the decision tree classifier.
package dtcs_pkg;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam int unsigned NUM_FEATURES = 64;
  localparam logic [63:0] FEATURE_MASK =
    (NUM_FEATURES >= 64) ? {64{1'b1}} : ((64'd1 << NUM_FEATURES) - 64'd1);

  localparam int unsigned TABLE_DEPTH = 512;
  localparam int unsigned ADDR_W      = 9;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLASSIFY,
    OP_CLEAR
  } op_t;

  // One node table entry: leaf flag and either a feature index or a class.
  typedef struct packed {
    logic       leaf;
    logic [5:0] payload;
  } node_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] node_index;
    node_t             node;
    logic [63:0]       features;
    logic [3:0]        true_class;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } back_state_t;

endpackage

// File: design/dtcs_front.sv
// Front end: decodes input transactions, drops no-op commands, queues the rest.
module dtcs_front
  import dtcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             clearing,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       cmd,
  input  logic [8:0]       node_index,
  input  logic             node_is_leaf,
  input  logic [5:0]       node_feature,
  input  logic [3:0]       node_class,
  input  logic [63:0]      features,
  input  logic [3:0]       true_class,
  output logic             q_valid,
  output q_entry_t         q_entry,
  input  logic             q_pop
);

  q_entry_t          queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              keep;
  logic              push;
  q_entry_t          entry;

  always_comb begin
    entry.op         = OP_WRITE;
    keep             = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        entry.op = OP_WRITE;
        keep     = (node_index != '0);
      end
      CMD_CLASSIFY: begin
        entry.op = OP_CLASSIFY;
        keep     = 1'b1;
      end
      CMD_CLEAR: begin
        entry.op = OP_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        entry.op = OP_WRITE;
        keep     = 1'b0;
      end
    endcase
    entry.node_index   = node_index;
    entry.node.leaf    = node_is_leaf;
    // A leaf keeps only its class, an inner node only its feature index.
    entry.node.payload = node_is_leaf ? {2'b00, node_class} : node_feature;
    entry.features     = features & FEATURE_MASK;
    entry.true_class   = true_class;
  end

  assign in_stall = clearing || (count == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count != '0);
  assign q_entry  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/dtcs_back.sv
// Back end: node table, clearing pass, tree walk, tallies and result register.
module dtcs_back
  import dtcs_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  output logic        clearing,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  predicted_class,
  output logic        correct,
  output logic        walk_error,
  output logic [31:0] tally_correct,
  output logic [31:0] tally_wrong,
  output logic        all_correct
);

  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_DEPTH);

  node_t             mem [TABLE_DEPTH];
  node_t             rdata;
  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] pos_next;
  logic [LVL_W-1:0]  level;
  logic [LVL_W-1:0]  level_next;
  logic [63:0]       feats;
  logic [3:0]        tcls;
  logic [31:0]       correct_cnt;
  logic [31:0]       correct_cnt_next;
  logic [31:0]       wrong_cnt;
  logic [31:0]       wrong_cnt_next;
  logic              all_ok;
  logic              all_ok_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  node_t             mem_wd;
  logic [ADDR_W-1:0] rd_addr;
  logic              start_walk;
  logic              tested_bit;
  logic [ADDR_W:0]   child;
  logic              walk_end;
  logic              slot_free;
  logic              finish;
  logic              hit;
  logic [3:0]        pred;

  assign clearing   = (state == ST_CLEAR);
  assign tested_bit = feats[rdata.payload];
  assign child      = {pos, tested_bit};
  assign walk_end   = (state == ST_WALK) &&
                      (rdata.leaf || (level == LVL_MAX) || child[ADDR_W]);
  assign slot_free  = !out_valid || !out_stall;
  assign finish     = walk_end && slot_free;
  assign hit        = rdata.leaf;
  assign pred       = hit ? rdata.payload[3:0] : 4'd0;

  always_comb begin
    state_next       = state;
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    mem_wa           = q_entry.node_index;
    mem_wd           = q_entry.node;
    rd_addr          = pos;
    pos_next         = pos;
    level_next       = level;
    start_walk       = 1'b0;
    correct_cnt_next = correct_cnt;
    wrong_cnt_next   = wrong_cnt;
    all_ok_next      = all_ok;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '{leaf: 1'b1, payload: 6'd0};
        if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_entry.op)
            OP_WRITE: begin
              mem_we = 1'b1;
            end
            OP_CLEAR: begin
              correct_cnt_next = '0;
              wrong_cnt_next   = '0;
              all_ok_next      = 1'b1;
            end
            OP_CLASSIFY: begin
              start_walk = 1'b1;
              rd_addr    = ADDR_W'(1);
              pos_next   = ADDR_W'(1);
              level_next = '0;
              state_next = ST_WALK;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          // Hold the read address so the node stays put while the output waits.
          if (slot_free) begin
            state_next = ST_IDLE;
            if (hit && (pred == tcls)) begin
              if (correct_cnt != '1) begin
                correct_cnt_next = correct_cnt + 32'd1;
              end
            end else begin
              if (wrong_cnt != '1) begin
                wrong_cnt_next = wrong_cnt + 32'd1;
              end
              all_ok_next = 1'b0;
            end
          end
        end else begin
          rd_addr    = child[ADDR_W-1:0];
          pos_next   = child[ADDR_W-1:0];
          level_next = level + 1'b1;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    level <= level_next;
    if (start_walk) begin
      feats <= q_entry.features;
      tcls  <= q_entry.true_class;
    end
    if (finish) begin
      predicted_class <= pred;
      correct         <= hit && (pred == tcls);
      walk_error      <= !hit;
      tally_correct   <= correct_cnt_next;
      tally_wrong     <= wrong_cnt_next;
      all_correct     <= all_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      correct_cnt <= '0;
      wrong_cnt   <= '0;
      all_ok      <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      correct_cnt <= correct_cnt_next;
      wrong_cnt   <= wrong_cnt_next;
      all_ok      <= all_ok_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/decision_tree_classify_score_top.sv
// Top level of the decision tree classifier with running accuracy tallies.
//
// Input channel (in_valid / in_stall) carries one command per transaction:
// write a node of the 512-entry heap-ordered tree, classify an example, or
// clear the tallies. Writes to node zero and unknown commands are dropped.
// Output channel (out_valid / out_stall) carries one result per classify:
// predicted class, correct, walk_error and the tallies after that example.
//
// Accepted commands enter a four-entry queue; the back end runs them in order.
// A write or clear is handled in the idle state of the back end. A classify
// walks the tree there one level per cycle, set by the single read port of
// the node table; a walk that finds no leaf stops after MAX_DEPTH + 1 levels
// or when the heap index passes 511.
//
// After reset the node table is swept to leaf-of-class-0, one entry per
// cycle; in_stall stays high throughout. A stalled result holds on the
// output and the back end waits to finish the next classify, while the
// queue keeps taking commands until it is full.
module decision_tree_classify_score_top
  import dtcs_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [8:0]  node_index,
  input  logic        node_is_leaf,
  input  logic [5:0]  node_feature,
  input  logic [3:0]  node_class,
  input  logic [63:0] features,
  input  logic [3:0]  true_class,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  predicted_class,
  output logic        correct,
  output logic        walk_error,
  output logic [31:0] tally_correct,
  output logic [31:0] tally_wrong,
  output logic        all_correct
);

  logic     clearing;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  dtcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_feature (node_feature),
    .node_class   (node_class),
    .features     (features),
    .true_class   (true_class),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  dtcs_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .clearing        (clearing),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .predicted_class (predicted_class),
    .correct         (correct),
    .walk_error      (walk_error),
    .tally_correct   (tally_correct),
    .tally_wrong     (tally_wrong),
    .all_correct     (all_correct)
  );

endmodule

// File: design/dtcs_checker.sv
// Port-level checks for the decision tree classifier, bound to the top level.
module dtcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  predicted_class,
  input logic        correct,
  input logic        walk_error,
  input logic [31:0] tally_wrong,
  input logic        all_correct
);

  // The table sweep after reset must hold off the input channel.
  a_stall_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input accepted during table clearing");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(predicted_class) &&
      $stable(tally_wrong) && $stable(all_correct))
    else $error("stalled result changed");

  a_error_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && walk_error |-> (predicted_class == 4'd0) && !correct && !all_correct)
    else $error("walk error result is inconsistent");

  // The all-correct flag drops exactly when the wrong tally leaves zero.
  a_flag_vs_tally: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (all_correct == (tally_wrong == 32'd0)))
    else $error("all_correct disagrees with wrong tally");

endmodule

bind decision_tree_classify_score_top dtcs_checker u_dtcs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .predicted_class (predicted_class),
  .correct         (correct),
  .walk_error      (walk_error),
  .tally_wrong     (tally_wrong),
  .all_correct     (all_correct)
);
